>>> hdl/sme_pkg.sv
// shared types, constants and opcode codes of the stack machine executor
`default_nettype none
package sme_pkg;
  localparam int StackDepth = 64;
  localparam int CallDepth  = 32;
  localparam int Vars       = 64;
  localparam int ProgMax    = 1024;
  localparam int SaW = $clog2(StackDepth);
  localparam int RaW = $clog2(CallDepth);
  localparam int VaW = $clog2(Vars);
  localparam int PcW = 11;

  typedef enum logic [3:0] {
    OP_PUSH = 4'd0, OP_MUL = 4'd1, OP_ADD = 4'd2, OP_SUB = 4'd3, OP_DIV = 4'd4,
    OP_PRINT = 4'd5, OP_LOAD = 4'd6, OP_STORE = 4'd7, OP_JUMP = 4'd8, OP_JIF = 4'd9,
    OP_EQ = 4'd10, OP_LT = 4'd11, OP_GT = 4'd12, OP_CALL = 4'd13, OP_RET = 4'd14,
    OP_NOP = 4'd15
  } op_t;

  typedef enum logic [3:0] {
    ERR_NONE = 4'd0, ERR_UNDER = 4'd1, ERR_OVER = 4'd2, ERR_UNSET = 4'd3,
    ERR_TARGET = 4'd4, ERR_RET_UNDER = 4'd5, ERR_CALL_OVER = 4'd6,
    ERR_VAR_IDX = 4'd7, ERR_DIV_ZERO = 4'd8
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD1, ST_RD2, ST_EXEC, ST_MUL, ST_DIV, ST_WB, ST_OUT
  } state_t;

  localparam logic [31:0] QOne = 32'h0001_0000;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -66'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

>>> hdl/stack_machine_executor.sv
// top level of the stack machine executor
// Usage: load program_length through the cfg_ apb port (address 0) while idle,
// then feed one fetched instruction (in_func, in_operand) per transaction on
// the in_ channel. Each instruction yields one result transaction on the out_
// channel: next pc, printed value, sticky error code and halt flag.
// The value stack, return stack and variable store live in single-port
// synchronous rams; the control reads the top entries, computes and writes back.
// Each instruction passes through ST_RD1 and ST_RD2 (the two stack reads),
// ST_EXEC and ST_OUT (output load); mul adds ST_MUL (product) and ST_WB
// (write-back); div starts the divider, waits in ST_DIV for its 48 steps, then ST_WB.
// One instruction is in flight at a time; in_ready returns in the cycle after
// the result is loaded; none is taken while one is still executing.
// A result waits in the output register while out_ready is low; the next
// instruction still executes and then holds before its own result is loaded.
// Reset clears counts, pc, error latch and the variable valid marks at once;
// no clearing pass is needed.
`default_nettype none
module stack_machine_executor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [3:0]  in_func,
  input  wire logic signed [31:0] in_operand,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [10:0] out_next_pc,
  output      logic        out_print_valid,
  output      logic signed [31:0] out_print_value,
  output      logic [3:0]  out_error,
  output      logic        out_halted,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic        cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output      logic [31:0] cfg_prdata,
  output      logic        cfg_pready
);
  import sme_pkg::*;

  state_t st_r, st_nxt;
  logic [PcW-1:0] len_r, pc_r, pc_nxt;
  logic [SaW:0]   n_r, n_nxt;
  logic [RaW:0]   rn_r, rn_nxt;
  logic [3:0]     err_r, err_nxt;
  logic [Vars-1:0] vv_r, vv_nxt;
  op_t            op_r;
  logic [31:0]    opnd_r, top_r, top_nxt, res_r, res_nxt;
  logic [31:0]    pval_r, pval_nxt;
  logic signed [63:0] prod_r;
  logic           ov_r, ov_nxt, opv_r, opv_nxt;
  logic [PcW-1:0] onpc_r, onpc_nxt;
  logic           opr_r, opr_nxt;
  logic [31:0]    oval_r, oval_nxt;
  logic [3:0]     oerr_r, oerr_nxt;

  // ram ports
  logic           vs_we, rs_we, vr_we;
  logic [SaW-1:0] vs_a;
  logic [RaW-1:0] rs_a;
  logic [VaW-1:0] vr_a;
  logic [31:0]    vs_wd, vs_rd, vr_rd;
  logic [PcW-1:0] rs_wd, rs_rd;
  logic           div_start, div_done;
  logic [31:0]    div_q;

  sme_ram #(.Width(32), .Depth(StackDepth)) u_vs (
    .clk(clk), .we(vs_we), .addr(vs_a), .wdata(vs_wd), .rdata(vs_rd));
  sme_ram #(.Width(PcW), .Depth(CallDepth)) u_rs (
    .clk(clk), .we(rs_we), .addr(rs_a), .wdata(rs_wd), .rdata(rs_rd));
  sme_ram #(.Width(32), .Depth(Vars)) u_vr (
    .clk(clk), .we(vr_we), .addr(vr_a), .wdata(top_r), .rdata(vr_rd));
  sme_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(vs_rd), .den(top_r),
    .done(div_done), .quot(div_q));

  // derived checks
  logic [PcW-1:0] elen;
  logic           var_ok, jmp_ok, call_ok, run, binop;
  logic [31:0]    lval;
  logic signed [65:0] msh;
  assign elen = (len_r > PcW'(ProgMax)) ? PcW'(ProgMax) : len_r;
  assign var_ok = (opnd_r[31:VaW] == '0);
  assign jmp_ok = (opnd_r[31:PcW] == '0) && (opnd_r[PcW-1:0] <= elen);
  assign call_ok = (opnd_r[31:PcW] == '0) && (opnd_r[PcW-1:0] < elen);
  assign run = (err_r == ERR_NONE) && (pc_r < elen);
  assign binop = (op_r == OP_MUL) || (op_r == OP_ADD) || (op_r == OP_SUB) ||
                 (op_r == OP_DIV) || (op_r == OP_EQ) || (op_r == OP_LT) ||
                 (op_r == OP_GT);
  assign lval = vs_rd;
  assign msh = 66'(prod_r >>> 16);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_valid && in_ready) st_nxt = ST_RD1;
      ST_RD1:  st_nxt = ST_RD2;
      ST_RD2:  st_nxt = ST_EXEC;
      ST_EXEC: begin
        if (run && binop && n_r >= 2 && op_r == OP_MUL) st_nxt = ST_MUL;
        else if (run && binop && n_r >= 2 && op_r == OP_DIV && top_r != '0) st_nxt = ST_DIV;
        else st_nxt = ST_OUT;
      end
      ST_MUL:  st_nxt = ST_WB;
      ST_DIV:  if (div_done) st_nxt = ST_WB;
      ST_WB:   st_nxt = ST_OUT;
      ST_OUT:  if (!ov_r || out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    pc_nxt = pc_r; n_nxt = n_r; rn_nxt = rn_r; err_nxt = err_r; vv_nxt = vv_r;
    top_nxt = top_r; res_nxt = res_r; ov_nxt = ov_r; opv_nxt = opv_r;
    pval_nxt = pval_r;
    onpc_nxt = onpc_r; opr_nxt = opr_r; oval_nxt = oval_r; oerr_nxt = oerr_r;
    vs_we = 1'b0; rs_we = 1'b0; vr_we = 1'b0; div_start = 1'b0;
    vs_a = SaW'(n_r - 1'b1); rs_a = RaW'(rn_r - 1'b1); vr_a = opnd_r[VaW-1:0];
    vs_wd = opnd_r; rs_wd = PcW'(pc_r + 1'b1);
    if (out_valid && out_ready) ov_nxt = 1'b0;
    case (st_r)
      ST_RD1: vs_a = SaW'(n_r - 1'b1);
      ST_RD2: begin
        top_nxt = vs_rd;
        vs_a = SaW'(n_r - 2'd2);
      end
      ST_EXEC: begin
        vs_a = SaW'(n_r - 2'd2);
        opv_nxt = 1'b0; pval_nxt = '0;
        if (run) begin
          case (op_r)
            OP_PUSH: begin
              if (n_r >= (SaW+1)'(StackDepth)) err_nxt = ERR_OVER;
              else begin
                vs_a = SaW'(n_r); vs_we = 1'b1; n_nxt = n_r + 1'b1;
              end
            end
            OP_MUL, OP_ADD, OP_SUB, OP_DIV, OP_EQ, OP_LT, OP_GT: begin
              if (n_r < 2) err_nxt = ERR_UNDER;
              else if (op_r == OP_DIV && top_r == '0) err_nxt = ERR_DIV_ZERO;
              else if (op_r == OP_DIV) div_start = 1'b1;
              else if (op_r != OP_MUL) begin
                case (op_r)
                  OP_ADD: vs_wd = sat32(66'($signed(lval)) + 66'($signed(top_r)));
                  OP_SUB: vs_wd = sat32(66'($signed(lval)) - 66'($signed(top_r)));
                  OP_EQ:  vs_wd = (lval == top_r) ? QOne : '0;
                  OP_LT:  vs_wd = ($signed(lval) < $signed(top_r)) ? QOne : '0;
                  default: vs_wd = ($signed(lval) > $signed(top_r)) ? QOne : '0;
                endcase
                vs_we = 1'b1; n_nxt = n_r - 1'b1;
              end
            end
            OP_PRINT: begin
              if (n_r == '0) err_nxt = ERR_UNDER;
              else begin
                opv_nxt = 1'b1; pval_nxt = top_r; n_nxt = n_r - 1'b1;
              end
            end
            OP_LOAD: begin
              if (!var_ok) err_nxt = ERR_VAR_IDX;
              else if (!vv_r[opnd_r[VaW-1:0]]) err_nxt = ERR_UNSET;
              else if (n_r >= (SaW+1)'(StackDepth)) err_nxt = ERR_OVER;
              else begin
                vs_a = SaW'(n_r); vs_wd = vr_rd; vs_we = 1'b1; n_nxt = n_r + 1'b1;
              end
            end
            OP_STORE: begin
              if (!var_ok) err_nxt = ERR_VAR_IDX;
              else if (n_r == '0) err_nxt = ERR_UNDER;
              else begin
                vs_a = SaW'(n_r - 1'b1); vr_we = 1'b1;
                vv_nxt[opnd_r[VaW-1:0]] = 1'b1; n_nxt = n_r - 1'b1;
              end
            end
            OP_JUMP: begin
              if (!jmp_ok) err_nxt = ERR_TARGET;
              else pc_nxt = opnd_r[PcW-1:0];
            end
            OP_JIF: begin
              if (!jmp_ok) err_nxt = ERR_TARGET;
              else if (n_r == '0) err_nxt = ERR_UNDER;
              else begin
                n_nxt = n_r - 1'b1;
                pc_nxt = (top_r == '0) ? opnd_r[PcW-1:0] : PcW'(pc_r + 1'b1);
              end
            end
            OP_CALL: begin
              if (!call_ok) err_nxt = ERR_TARGET;
              else if (rn_r >= (RaW+1)'(CallDepth)) err_nxt = ERR_CALL_OVER;
              else begin
                rs_a = RaW'(rn_r); rs_we = 1'b1; rn_nxt = rn_r + 1'b1;
                pc_nxt = opnd_r[PcW-1:0];
              end
            end
            OP_RET: begin
              if (rn_r == '0) err_nxt = ERR_RET_UNDER;
              else begin
                rn_nxt = rn_r - 1'b1; pc_nxt = rs_rd;
              end
            end
            default: ;
          endcase
          // plain advance for every opcode other than jump, jif, call and ret
          if (!(op_r == OP_JUMP || op_r == OP_JIF || op_r == OP_CALL || op_r == OP_RET))
            pc_nxt = PcW'(pc_r + 1'b1);
          if (err_nxt != err_r) begin
            pc_nxt = pc_r; n_nxt = n_r; rn_nxt = rn_r; vv_nxt = vv_r;
            vs_we = 1'b0; rs_we = 1'b0; vr_we = 1'b0; div_start = 1'b0;
            opv_nxt = 1'b0; pval_nxt = '0;
          end
        end
      end
      ST_MUL: res_nxt = sat32(msh);
      ST_DIV: res_nxt = div_q;
      ST_WB: begin
        vs_a = SaW'(n_r - 2'd2); vs_wd = res_r; vs_we = 1'b1; n_nxt = n_r - 1'b1;
      end
      ST_OUT: begin
        // load the result once the output register is free
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1; onpc_nxt = pc_r; opr_nxt = opv_r; oval_nxt = pval_r;
          oerr_nxt = err_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ready = (st_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= op_t'(in_func); opnd_r <= in_operand;
    end
    top_r <= top_nxt; res_r <= res_nxt; opv_r <= opv_nxt; pval_r <= pval_nxt;
    prod_r <= $signed(lval) * $signed(top_r);
    onpc_r <= onpc_nxt; opr_r <= opr_nxt; oval_r <= oval_nxt; oerr_r <= oerr_nxt;
    if (!rst_n) begin
      st_r <= ST_IDLE; pc_r <= '0; n_r <= '0; rn_r <= '0; err_r <= '0;
      vv_r <= '0; ov_r <= 1'b0; len_r <= '0;
    end else begin
      st_r <= st_nxt; pc_r <= pc_nxt; n_r <= n_nxt; rn_r <= rn_nxt;
      err_r <= err_nxt; vv_r <= vv_nxt; ov_r <= ov_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr) len_r <= cfg_pwdata[PcW-1:0];
    end
  end

  // result register outputs
  assign out_valid = ov_r;
  assign out_next_pc = onpc_r;
  assign out_print_valid = opr_r;
  assign out_print_value = oval_r;
  assign out_error = oerr_r;
  assign out_halted = (oerr_r != ERR_NONE) || (onpc_r >= elen);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr ? '0 : {21'd0, len_r};
endmodule
`default_nettype wire

>>> hdl/sme_ram.sv
// generic single-port ram with registered read
`default_nettype none
module sme_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> hdl/sme_div.sv
// sequential signed q16.16 divider, one quotient bit per cycle
`default_nettype none
module sme_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [31:0] den,
  output      logic        done,
  output      logic [31:0] quot
);
  import sme_pkg::*;
  logic [47:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] d_r, d_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] trial;
  logic signed [65:0] sq;
  logic [31:0] an, ad;

  assign an = num[31] ? (~num + 32'd1) : num;
  assign ad = den[31] ? (~den + 32'd1) : den;
  assign trial = {rem_r[31:0], q_r[47]} - {1'b0, d_r};
  assign sq = neg_r ? -$signed({18'd0, q_r}) : $signed({18'd0, q_r});

  // shift-subtract step over 48 dividend bits
  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; neg_nxt = neg_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      q_nxt = {an, 16'd0}; rem_nxt = '0; d_nxt = ad;
      neg_nxt = num[31] ^ den[31]; cnt_nxt = 6'd48; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial; q_nxt = {q_r[46:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], q_r[47]}; q_nxt = {q_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt; neg_r <= neg_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = sat32(sq);
endmodule
`default_nettype wire

>>> tb/tb_stack_machine_executor.sv
// self-checking testbench for the stack machine executor
`default_nettype none
module tb_stack_machine_executor;
  import sme_pkg::*;

  localparam int Gen = 0;  // shadow machine used to pick legal instructions
  localparam int Chk = 1;  // machine that predicts the block's results
  localparam int IdleLimit = 5000;
  localparam int Settle = 80;
  localparam logic RegProgramLength = 1'b0;

  typedef struct packed {
    logic [10:0] npc;
    logic        pv;
    logic [31:0] pval;
    logic [3:0]  err;
    logic        halted;
  } step_result_t;

  typedef struct packed {
    op_t         f;
    logic [31:0] opd;
  } insn_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] in_func = '0;
  logic signed [31:0] in_operand = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [10:0] out_next_pc;
  logic out_print_valid;
  logic signed [31:0] out_print_value;
  logic [3:0] out_error;
  logic out_halted;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic cfg_paddr = 1'b0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  stack_machine_executor u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func), .in_operand(in_operand),
    .out_valid(out_valid), .out_ready(out_ready), .out_next_pc(out_next_pc),
    .out_print_valid(out_print_valid), .out_print_value(out_print_value),
    .out_error(out_error), .out_halted(out_halted),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // machine state, one copy for the generator and one for the checker
  logic signed [31:0] m_vs[2][StackDepth];
  int                 m_vn[2];
  logic [10:0]        m_rs[2][CallDepth];
  int                 m_rn[2];
  logic signed [31:0] m_var[2][Vars];
  logic               m_vok[2][Vars];
  int unsigned        m_pc[2];
  err_t               m_err[2];
  int unsigned        m_len[2];

  insn_t        pend_q[$];
  step_result_t result_q[$];
  int n_fail = 0;
  int n_insn = 0;
  int n_results = 0;
  int n_prints = 0;

  function automatic int unsigned eff_len(input int k);
    return (m_len[k] > ProgMax) ? ProgMax : m_len[k];
  endfunction

  function automatic logic signed [31:0] clamp_q(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // execute one instruction on machine k and form the result transaction
  task automatic run_insn(input int k, input op_t f, input logic signed [31:0] opd,
                          output step_result_t r);
    int unsigned len;
    int unsigned npc;
    int n;
    err_t e;
    logic pv;
    logic signed [31:0] pval, lhs, rhs, q;
    longint p;
    len = eff_len(k);
    n = m_vn[k];
    e = ERR_NONE;
    npc = m_pc[k] + 1;
    pv = 1'b0;
    pval = '0;
    q = '0;
    if (m_err[k] == ERR_NONE && m_pc[k] < len) begin
      case (f)
        OP_PUSH: begin
          if (n >= StackDepth) e = ERR_OVER;
          else begin
            m_vs[k][n] = opd;
            m_vn[k] = n + 1;
          end
        end
        OP_MUL, OP_ADD, OP_SUB, OP_DIV, OP_EQ, OP_LT, OP_GT: begin
          if (n < 2) e = ERR_UNDER;
          else begin
            rhs = m_vs[k][n-1];
            lhs = m_vs[k][n-2];
            case (f)
              OP_MUL: begin
                p = longint'(lhs) * longint'(rhs);
                q = clamp_q(p >>> 16);
              end
              OP_ADD: q = clamp_q(longint'(lhs) + longint'(rhs));
              OP_SUB: q = clamp_q(longint'(lhs) - longint'(rhs));
              OP_DIV: begin
                if (rhs == 0) e = ERR_DIV_ZERO;
                else q = clamp_q((longint'(lhs) * 65536) / longint'(rhs));
              end
              OP_EQ: q = (lhs == rhs) ? QOne : '0;
              OP_LT: q = (lhs < rhs) ? QOne : '0;
              default: q = (lhs > rhs) ? QOne : '0;
            endcase
            if (e == ERR_NONE) begin
              m_vs[k][n-2] = q;
              m_vn[k] = n - 1;
            end
          end
        end
        OP_PRINT: begin
          if (n == 0) e = ERR_UNDER;
          else begin
            pv = 1'b1;
            pval = m_vs[k][n-1];
            m_vn[k] = n - 1;
          end
        end
        OP_LOAD: begin
          if (opd < 0 || opd >= Vars) e = ERR_VAR_IDX;
          else if (!m_vok[k][opd]) e = ERR_UNSET;
          else if (n >= StackDepth) e = ERR_OVER;
          else begin
            m_vs[k][n] = m_var[k][opd];
            m_vn[k] = n + 1;
          end
        end
        OP_STORE: begin
          if (opd < 0 || opd >= Vars) e = ERR_VAR_IDX;
          else if (n == 0) e = ERR_UNDER;
          else begin
            m_var[k][opd] = m_vs[k][n-1];
            m_vok[k][opd] = 1'b1;
            m_vn[k] = n - 1;
          end
        end
        OP_JUMP: begin
          if (opd < 0 || opd > len) e = ERR_TARGET;
          else npc = opd;
        end
        OP_JIF: begin
          if (opd < 0 || opd > len) e = ERR_TARGET;
          else if (n == 0) e = ERR_UNDER;
          else begin
            if (m_vs[k][n-1] == 0) npc = opd;
            m_vn[k] = n - 1;
          end
        end
        OP_CALL: begin
          if (opd < 0 || opd >= len) e = ERR_TARGET;
          else if (m_rn[k] >= CallDepth) e = ERR_CALL_OVER;
          else begin
            m_rs[k][m_rn[k]] = 11'(m_pc[k] + 1);
            m_rn[k] = m_rn[k] + 1;
            npc = opd;
          end
        end
        OP_RET: begin
          if (m_rn[k] == 0) e = ERR_RET_UNDER;
          else begin
            m_rn[k] = m_rn[k] - 1;
            npc = m_rs[k][m_rn[k]];
          end
        end
        default: ;
      endcase
      if (e != ERR_NONE) begin
        m_err[k] = e;
        pv = 1'b0;
        pval = '0;
      end else m_pc[k] = npc;
    end
    r.npc = m_pc[k][10:0];
    r.pv = pv;
    r.pval = pval;
    r.err = m_err[k];
    r.halted = (m_err[k] != ERR_NONE) || (m_pc[k] >= len);
  endtask

  task automatic queue_insn(input op_t f, input logic [31:0] opd);
    step_result_t dummy;
    insn_t it;
    run_insn(Gen, f, opd, dummy);
    it.f = f;
    it.opd = opd;
    pend_q.insert(pend_q.size(), it);
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 4))
      0: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      1: return ($urandom_range(0, 1) != 0) ? 32'h0 : 32'hffff_ffff;
      2: return 32'($urandom_range(0, 16)) << 16;
      3: return -(32'($urandom_range(0, 16)) << 16) + 32'($urandom_range(0, 65535));
      default: return $urandom();
    endcase
  endfunction

  // one legal instruction picked from the generator's view of the machine
  task automatic queue_random_insn();
    op_t f;
    int n, idx;
    int unsigned len;
    n = m_vn[Gen];
    len = eff_len(Gen);
    if (m_pc[Gen] + 2 >= len) begin
      queue_insn(OP_JUMP, $urandom_range(0, len / 2));
    end else begin
      f = op_t'($urandom_range(0, 15));
      idx = $urandom_range(0, ($urandom_range(0, 1) != 0) ? 7 : Vars - 1);
      if (f == OP_LOAD && (!m_vok[Gen][idx] || n >= StackDepth - 2)) f = OP_PUSH;
      if (f == OP_PUSH && n >= StackDepth - 2) f = OP_PRINT;
      if (f == OP_RET && m_rn[Gen] == 0) f = OP_CALL;
      if (f == OP_CALL && m_rn[Gen] >= CallDepth) f = OP_RET;
      if ((f == OP_MUL || f == OP_ADD || f == OP_SUB || f == OP_DIV || f == OP_EQ ||
           f == OP_LT || f == OP_GT) && n < 2) f = OP_PUSH;
      if ((f == OP_PRINT || f == OP_STORE || f == OP_JIF) && n < 1) f = OP_PUSH;
      if (f == OP_DIV && m_vs[Gen][n-1] == 0) f = OP_SUB;
      case (f)
        OP_PUSH: queue_insn(f, rand_q());
        OP_LOAD, OP_STORE: queue_insn(f, idx);
        OP_JUMP, OP_JIF, OP_CALL: queue_insn(f, $urandom_range(0, len - 1));
        default: queue_insn(f, $urandom());
      endcase
    end
  endtask

  // unwind calls and return to the start so a new length never strands pc
  task automatic queue_unwind();
    while (m_rn[Gen] > 0) queue_insn(OP_RET, $urandom());
    queue_insn(OP_JUMP, 0);
  endtask

  task automatic wait_idle();
    while (pend_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  // apb write: setup cycle then access cycle
  task automatic write_length(input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= RegProgramLength;
    cfg_pwdata <= value;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    m_len[Gen] = value[10:0];
    m_len[Chk] = value[10:0];
  endtask

  // drive the machine into one randomly chosen fault
  task automatic queue_fault();
    int idx;
    int unsigned len;
    err_t kind;
    len = eff_len(Gen);
    kind = err_t'($urandom_range(1, 8));
    case (kind)
      ERR_UNDER: begin
        while (m_vn[Gen] > 0) queue_insn(OP_PRINT, $urandom());
        queue_insn(OP_PRINT, $urandom());
      end
      ERR_OVER: begin
        while (m_vn[Gen] < StackDepth) queue_insn(OP_PUSH, rand_q());
        queue_insn(OP_PUSH, rand_q());
      end
      ERR_UNSET: begin
        idx = -1;
        for (int i = 0; i < Vars; i++) if (!m_vok[Gen][i]) idx = i;
        queue_insn(OP_LOAD, idx);
      end
      ERR_TARGET: begin
        if ($urandom_range(0, 1) != 0) queue_insn(OP_JUMP, len + 1 + $urandom_range(0, 100));
        else queue_insn(OP_CALL, 32'h8000_0000 | $urandom());
      end
      ERR_RET_UNDER: begin
        while (m_rn[Gen] > 0) queue_insn(OP_RET, $urandom());
        queue_insn(OP_RET, $urandom());
      end
      ERR_CALL_OVER: begin
        while (m_rn[Gen] < CallDepth) queue_insn(OP_CALL, $urandom_range(0, len - 1));
        queue_insn(OP_CALL, $urandom_range(0, len - 1));
      end
      ERR_VAR_IDX: begin
        if ($urandom_range(0, 1) != 0) queue_insn(OP_STORE, Vars + $urandom_range(0, 1000));
        else queue_insn(OP_LOAD, 32'hffff_ffff);
      end
      default: begin
        if (m_vn[Gen] > StackDepth - 2) queue_insn(OP_PRINT, 0);
        queue_insn(OP_PUSH, rand_q());
        queue_insn(OP_PUSH, 32'h0);
        queue_insn(OP_DIV, $urandom());
      end
    endcase
    // a halted machine ignores whatever follows
    repeat (5) queue_insn(op_t'($urandom_range(0, 15)), $urandom());
  endtask

  initial begin
    for (int k = 0; k < 2; k++) begin
      m_vn[k] = 0;
      m_rn[k] = 0;
      m_pc[k] = 0;
      m_err[k] = ERR_NONE;
      m_len[k] = 0;
      for (int i = 0; i < Vars; i++) m_vok[k][i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // zero length after reset: machine is halted from the start
    queue_insn(OP_NOP, 32'hffff_ffff);
    wait_idle();
    write_length(32'h7ff);

    // directed: saturation, every opcode, both branch outcomes, call and return
    queue_insn(OP_PUSH, 32'h7fff_ffff);
    queue_insn(OP_PUSH, 32'h7fff_ffff);
    queue_insn(OP_ADD, 32'h0);
    queue_insn(OP_PUSH, 32'h8000_0000);
    queue_insn(OP_MUL, 32'hffff_ffff);
    queue_insn(OP_PUSH, 32'hffff_0000);
    queue_insn(OP_DIV, 32'h0);
    queue_insn(OP_PUSH, 32'h0001_8000);
    queue_insn(OP_SUB, 32'h0);
    queue_insn(OP_STORE, Vars - 1);
    queue_insn(OP_LOAD, Vars - 1);
    queue_insn(OP_LOAD, Vars - 1);
    queue_insn(OP_EQ, 32'h0);
    queue_insn(OP_PUSH, 32'h0);
    queue_insn(OP_LT, 32'h0);
    queue_insn(OP_JIF, m_pc[Gen] + 2);
    queue_insn(OP_PUSH, 32'hffff_ffff);
    queue_insn(OP_PUSH, 32'h8000_0000);
    queue_insn(OP_GT, 32'h0);
    queue_insn(OP_JIF, m_pc[Gen] + 3);
    queue_insn(OP_CALL, m_pc[Gen] + 5);
    queue_insn(OP_NOP, 32'hffff_ffff);
    queue_insn(OP_RET, 32'h0);
    queue_insn(OP_PUSH, 32'h1234_5678);
    queue_insn(OP_STORE, 0);
    queue_insn(OP_LOAD, 0);
    queue_insn(OP_PRINT, 32'h0);
    queue_insn(OP_JUMP, 0);
    wait_idle();

    // jump onto the program length halts; a longer program resumes
    write_length(5);
    queue_insn(OP_JUMP, 5);
    queue_insn(OP_PUSH, 32'h1);
    wait_idle();
    write_length(32'h7ff);
    queue_insn(OP_JUMP, 0);
    wait_idle();

    // random programs under several lengths
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_length(ProgMax);
        1: write_length(3);
        default: write_length($urandom_range(3, ProgMax - 1));
      endcase
      repeat (230) queue_random_insn();
      queue_unwind();
      wait_idle();
    end

    write_length(ProgMax);
    queue_fault();
    wait_idle();

    $display("executed %0d instructions (%0d prints), checked %0d results",
             n_insn, n_prints, n_results);
    $display("final fault code %0d, %0d mismatches", m_err[Chk], n_fail);
    if (n_fail == 0 && result_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // instruction sender: bursts with random gaps, predicts on acceptance
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin : sender
    step_result_t r;
    insn_t it;
    logic taken;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && in_ready;
      if (taken) begin
        run_insn(Chk, op_t'(in_func), in_operand, r);
        result_q.insert(result_q.size(), r);
        n_insn++;
      end
      if (!in_valid || taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pend_q.size() != 0) begin
          it = pend_q.pop_front();
          in_valid <= 1'b1;
          in_func <= it.f;
          in_operand <= it.opd;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else burst_left--;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: cycles through four out_ready stall patterns
  int rx_cyc = 0;
  always @(posedge clk) begin : receiver
    step_result_t got, want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{npc: out_next_pc, pv: out_print_valid, pval: out_print_value,
                err: out_error, halted: out_halted};
        n_results++;
        if (out_print_valid) n_prints++;
        if (result_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("unexpected result transaction: pc %0d", got.npc);
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            n_fail++;
            if (n_fail <= 10)
              $display("res %0d: pc %0d/%0d pv %0b/%0b val %h/%h err %0d/%0d halt %0b/%0b",
                       n_results, got.npc, want.npc, got.pv, want.pv, got.pval, want.pval,
                       got.err, want.err, got.halted, want.halted);
          end
        end
      end
      rx_cyc++;
      case ((rx_cyc >> 8) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) != 0);
        2: out_ready <= ($urandom_range(0, 7) == 0);
        default: out_ready <= ((rx_cyc % 7) >= 3);
      endcase
    end
  end

  // watchdog on cycles with no transaction on either channel
  int stuck_cyc = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cyc <= 0;
    else stuck_cyc <= stuck_cyc + 1;
    if (stuck_cyc >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end
endmodule
`default_nettype wire

>>> sim.f
hdl/sme_pkg.sv
hdl/sme_ram.sv
hdl/sme_div.sv
hdl/stack_machine_executor.sv
tb/tb_stack_machine_executor.sv
